// File: rtl/hsv_to_rgb_converter_unit_macros.svh
// assertion macros for the port-level checker of the hsv to rgb converter
// depends on nothing; include by bare file name
`ifndef HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH

// concurrent assertion on a named clock and active-low reset
`define HSV_ASSERT(label, clk_sig, rstn_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
    else $error(msg);

// same, on the clk and rst_n of the enclosing scope
`define HSV_ASSERT_CLK(label, prop, msg) \
  `HSV_ASSERT(label, clk, rst_n, prop, msg)

`endif

// File: rtl/hsv2rgb_pkg.sv
// types and constants of the hsv to rgb converter pipeline
// depends on nothing; imported by every module of the block
package hsv2rgb_pkg;

  // one sector spans 60 degrees, levels are 8 bits
  localparam int unsigned SECTOR_DEG = 60;
  localparam int unsigned FULL_LEVEL = 255;
  localparam int unsigned DEN        = SECTOR_DEG * FULL_LEVEL;

  // start angle of each sector, indexed by hue / 60 (0..8 for a 9-bit hue)
  localparam logic [8:0] SECTOR_BASE [9] = '{
    9'd0, 9'd60, 9'd120, 9'd180, 9'd240, 9'd300, 9'd360, 9'd420, 9'd480
  };

  // reciprocal of 255: exact floor for products up to 255*255
  localparam logic [16:0]  RECIP_FULL       = 17'd65794;
  localparam int unsigned  RECIP_FULL_SHIFT = 24;
  // reciprocal of 15300: exact floor for products up to 255*15300
  localparam logic [22:0]  RECIP_DEN        = 23'd4491470;
  localparam int unsigned  RECIP_DEN_SHIFT  = 36;

  // colour wheel sectors
  typedef enum logic [2:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_t;

  // hue split into sector and remainder, with saturation and value
  typedef struct packed {
    sector_t    sector;
    logic [5:0] rem;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_split_t;

  // helper levels ready for channel selection
  typedef struct packed {
    sector_t    sector;
    logic [7:0] val;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
  } hsv_level_t;

endpackage

// File: rtl/hsv_to_rgb_converter_unit.sv
// HSV to RGB converter: takes one colour per clock while the output is not
// held off (hue 0..359 degrees, 8-bit saturation and value) and gives 8-bit
// red, green and blue by the six-sector method with truncated integer levels.
// It is a five-stage pipeline (sector split, factor products, value products,
// reciprocal divides, channel select). The first stage loads at the edge that
// accepts a transaction; the result then moves through the later stage
// registers in order to the outputs. One transaction can be taken every cycle
// unless the output is held off, and then the whole pipeline freezes; in_ready
// follows out_ready combinationally while a result is waiting. Hues above 359
// wrap.
// depends on hsv2rgb_pkg, hsv2rgb_sector, hsv2rgb_level, hsv2rgb_mux
module hsv_to_rgb_converter_unit
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [8:0] in_hue,
  input  logic [7:0] in_saturation,
  input  logic [7:0] in_brightness,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  logic [4:0] vld_r, vld_nxt;
  logic       en;
  hsv_split_t split_w;
  hsv_level_t level_w;

  // pipeline moves unless a finished result is held off
  assign en       = !vld_r[4] || out_ready;
  assign in_ready = en;
  assign vld_nxt  = {vld_r[3:0], in_valid};

  // valid bits travelling with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[4];

  hsv2rgb_sector u_sector (
    .clk     (clk),
    .en      (en),
    .hue     (in_hue),
    .sat     (in_saturation),
    .val     (in_brightness),
    .split_r (split_w)
  );

  hsv2rgb_level u_level (
    .clk     (clk),
    .en      (en),
    .split_i (split_w),
    .level_r (level_w)
  );

  hsv2rgb_mux u_mux (
    .clk     (clk),
    .en      (en),
    .level_i (level_w),
    .red_r   (out_red),
    .green_r (out_green),
    .blue_r  (out_blue)
  );

endmodule

// File: rtl/hsv2rgb_sector.sv
// first pipeline stage: hue to sector and remainder within the sector
// depends on hsv2rgb_pkg
module hsv2rgb_sector
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  logic [8:0] hue,
  input  logic [7:0] sat,
  input  logic [7:0] val,
  output hsv_split_t split_r
);

  hsv_split_t split_nxt;

  // parallel compares against sector starts, then subtract the start angle
  always_comb begin
    logic [3:0] quo;
    logic [8:0] diff;
    logic [3:0] wrapped;
    quo = 4'd0;
    for (int k = 1; k < 9; k++) begin
      quo = quo + {3'd0, (hue >= SECTOR_BASE[k])};
    end
    diff    = hue - SECTOR_BASE[quo];
    wrapped = (quo >= 4'd6) ? (quo - 4'd6) : quo;
    split_nxt.sector = sector_t'(wrapped[2:0]);
    split_nxt.rem    = diff[5:0];
    split_nxt.sat    = sat;
    split_nxt.val    = val;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (en) begin
      split_r <= split_nxt;
    end
  end

endmodule

// File: rtl/hsv2rgb_level.sv
// three pipeline stages computing the p, q and t levels
// depends on hsv2rgb_pkg
module hsv2rgb_level
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  hsv_split_t split_i,
  output hsv_level_t level_r
);

  localparam logic [13:0] DEN_W = 14'(DEN);
  localparam logic [7:0]  FULL_W = 8'(FULL_LEVEL);
  localparam logic [5:0]  DEG_W = 6'(SECTOR_DEG);

  // stage a: numerator factors
  sector_t     sec_a_r, sec_b_r;
  logic [7:0]  val_a_r, val_b_r;
  logic [13:0] dq_a_r, dt_a_r, dq_a_nxt, dt_a_nxt;
  logic [7:0]  dp_a_r, dp_a_nxt;
  // stage b: full products
  logic [21:0] xq_b_r, xt_b_r, xq_b_nxt, xt_b_nxt;
  logic [15:0] xp_b_r, xp_b_nxt;
  // stage c: reciprocal products
  logic [44:0] rq_w, rt_w;
  logic [32:0] rp_w;
  hsv_level_t  level_nxt;

  // drop terms rem*s and (60-rem)*s never exceed 15300
  always_comb begin
    logic [5:0] kt;
    kt       = DEG_W - split_i.rem;
    dq_a_nxt = DEN_W - (14'(split_i.rem) * 14'(split_i.sat));
    dt_a_nxt = DEN_W - (14'(kt) * 14'(split_i.sat));
    dp_a_nxt = FULL_W - split_i.sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sec_a_r <= split_i.sector;
      val_a_r <= split_i.val;
      dq_a_r  <= dq_a_nxt;
      dt_a_r  <= dt_a_nxt;
      dp_a_r  <= dp_a_nxt;
    end
  end

  // value times each factor
  assign xq_b_nxt = 22'(val_a_r) * 22'(dq_a_r);
  assign xt_b_nxt = 22'(val_a_r) * 22'(dt_a_r);
  assign xp_b_nxt = 16'(val_a_r) * 16'(dp_a_r);

  always_ff @(posedge clk) begin
    if (en) begin
      sec_b_r <= sec_a_r;
      val_b_r <= val_a_r;
      xq_b_r  <= xq_b_nxt;
      xt_b_r  <= xt_b_nxt;
      xp_b_r  <= xp_b_nxt;
    end
  end

  // truncating divides by 15300 and 255 through reciprocals
  assign rq_w = 45'(xq_b_r) * 45'(RECIP_DEN);
  assign rt_w = 45'(xt_b_r) * 45'(RECIP_DEN);
  assign rp_w = 33'(xp_b_r) * 33'(RECIP_FULL);

  always_comb begin
    level_nxt.sector = sec_b_r;
    level_nxt.val    = val_b_r;
    level_nxt.q      = rq_w[RECIP_DEN_SHIFT +: 8];
    level_nxt.t      = rt_w[RECIP_DEN_SHIFT +: 8];
    level_nxt.p      = rp_w[RECIP_FULL_SHIFT +: 8];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level_r <= level_nxt;
    end
  end

endmodule

// File: rtl/hsv2rgb_mux.sv
// last pipeline stage: routes value and levels to the channels by sector
// depends on hsv2rgb_pkg
module hsv2rgb_mux
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  hsv_level_t level_i,
  output logic [7:0] red_r,
  output logic [7:0] green_r,
  output logic [7:0] blue_r
);

  logic [7:0] red_nxt, green_nxt, blue_nxt;

  // six-sector channel assignment
  always_comb begin
    unique case (level_i.sector)
      SEC_RED_YELLOW: begin
        red_nxt = level_i.val; green_nxt = level_i.t;   blue_nxt = level_i.p;
      end
      SEC_YELLOW_GREEN: begin
        red_nxt = level_i.q;   green_nxt = level_i.val; blue_nxt = level_i.p;
      end
      SEC_GREEN_CYAN: begin
        red_nxt = level_i.p;   green_nxt = level_i.val; blue_nxt = level_i.t;
      end
      SEC_CYAN_BLUE: begin
        red_nxt = level_i.p;   green_nxt = level_i.q;   blue_nxt = level_i.val;
      end
      SEC_BLUE_MAGENTA: begin
        red_nxt = level_i.t;   green_nxt = level_i.p;   blue_nxt = level_i.val;
      end
      default: begin
        red_nxt = level_i.val; green_nxt = level_i.p;   blue_nxt = level_i.q;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

endmodule

// File: rtl/hsv2rgb_checker.sv
// port-level checks of the hsv to rgb converter, bound to its top level
// depends on hsv_to_rgb_converter_unit_macros.svh and the top level ports
`include "hsv_to_rgb_converter_unit_macros.svh"

module hsv2rgb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_saturation,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  // a stalled result keeps its colour
  `HSV_ASSERT_CLK(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_red) &&
      $stable(out_green) && $stable(out_blue),
    "stalled result changed")

  // input side only blocks while a result waits
  `HSV_ASSERT_CLK(a_in_ready,
    in_ready == (!out_valid || out_ready),
    "input held off without a waiting result")

  // free-flowing pipeline delivers a result once the transaction has passed every stage
  `HSV_ASSERT_CLK(a_latency,
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
      |=> out_valid,
    "result missing after pipeline latency")

  // zero saturation gives grey
  `HSV_ASSERT_CLK(a_grey,
    (in_valid && in_ready && in_saturation == 8'd0) ##1 out_ready ##1 out_ready
      ##1 out_ready ##1 out_ready |=> out_red == out_green && out_green == out_blue,
    "unsaturated colour is not grey")

endmodule

bind hsv_to_rgb_converter_unit hsv2rgb_checker u_hsv2rgb_checker (.*);

// File: verif/hsv_to_rgb_converter_checker.sv
// checker for the hsv to rgb converter: watches both channels, predicts rgb
// for every accepted colour and compares the results in order
// depends on hsv2rgb_pkg for the sector type and the level constants
`timescale 1ns / 1ps

module hsv_to_rgb_converter_checker
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [8:0] in_hue,
  input  logic [7:0] in_saturation,
  input  logic [7:0] in_brightness,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_red,
  input  logic [7:0] out_green,
  input  logic [7:0] out_blue,
  output int         mismatches,
  output int         colours_checked,
  output int         colours_awaited
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  rgb_t awaited_rgb[$];

  // level v * (60*255 - k*s) / (60*255), truncated
  function automatic logic [7:0] faded_level(logic [7:0] val, int unsigned k,
                                             logic [7:0] sat);
    int unsigned drop;
    drop = k * sat;
    if (drop > DEN) drop = DEN;
    return 8'((val * (DEN - drop)) / DEN);
  endfunction

  // six-sector conversion, hues above 359 wrap back into sectors 0..2
  function automatic rgb_t hsv_to_rgb(logic [8:0] hue, logic [7:0] sat,
                                      logic [7:0] val);
    sector_t     sector;
    int unsigned rem;
    logic [7:0]  p, q, t;
    rgb_t        rgb;
    sector = sector_t'((hue / SECTOR_DEG) % 6);
    rem    = hue % SECTOR_DEG;
    p      = 8'((val * (FULL_LEVEL - sat)) / FULL_LEVEL);
    q      = faded_level(val, rem, sat);
    t      = faded_level(val, SECTOR_DEG - rem, sat);
    unique case (sector)
      SEC_RED_YELLOW:   rgb = '{val, t, p};
      SEC_YELLOW_GREEN: rgb = '{q, val, p};
      SEC_GREEN_CYAN:   rgb = '{p, val, t};
      SEC_CYAN_BLUE:    rgb = '{p, q, val};
      SEC_BLUE_MAGENTA: rgb = '{t, p, val};
      default:          rgb = '{val, p, q};
    endcase
    return rgb;
  endfunction

  // one line per mismatch, and count it
  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // compare each result transaction, then record each new colour
  always @(posedge clk) begin
    rgb_t want;
    if (!rst_n) begin
      awaited_rgb.delete();
      mismatches      = 0;
      colours_checked = 0;
      colours_awaited = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_rgb.size() == 0) begin
          report_mismatch("result with no colour outstanding");
        end else begin
          want = awaited_rgb.pop_front();
          if (out_red !== want.red)
            report_mismatch($sformatf("red expected %0d, got %0d", want.red, out_red));
          if (out_green !== want.green)
            report_mismatch($sformatf("green expected %0d, got %0d", want.green,
                                      out_green));
          if (out_blue !== want.blue)
            report_mismatch($sformatf("blue expected %0d, got %0d", want.blue, out_blue));
          colours_checked++;
        end
      end
      if (in_valid && in_ready)
        awaited_rgb.push_back(hsv_to_rgb(in_hue, in_saturation, in_brightness));
      colours_awaited = awaited_rgb.size();
    end
  end

endmodule

// File: verif/testbench.sv
// top of the hsv to rgb converter testbench: clock, reset, colour stimulus,
// result back-pressure and the verdict
// depends on hsv_to_rgb_converter_unit and hsv_to_rgb_converter_checker
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_COLOURS = 1130;
  localparam int CYCLE_LIMIT    = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [8:0] in_hue = '0;
  logic [7:0] in_saturation = '0;
  logic [7:0] in_brightness = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_red, out_green, out_blue;

  logic steady = 1'b0;
  int   mismatches, colours_checked, colours_awaited;
  int   colours_sent = 0;
  int   wrapped_sent = 0;
  int   cycles = 0;

  always #2 clk = ~clk;

  hsv_to_rgb_converter_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  hsv_to_rgb_converter_checker colour_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_hue          (in_hue),
    .in_saturation   (in_saturation),
    .in_brightness   (in_brightness),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .mismatches      (mismatches),
    .colours_checked (colours_checked),
    .colours_awaited (colours_awaited)
  );

  // result back-pressure, none during the steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 26);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[hsv_to_rgb_converter_unit] ERROR");
      $finish;
    end
  end

  // present one colour and hold it until the transaction is taken
  task automatic send_colour(logic [8:0] hue, logic [7:0] sat, logic [7:0] val);
    in_valid      <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_brightness <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    colours_sent++;
    if (hue > 9'd359) wrapped_sent++;
    // idle the input now and then, each cycle with the same chance
    while (!steady && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // saturation or brightness, leaning on the extremes now and then
  function automatic logic [7:0] pick_level();
    unique case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(3));
      3:       return 8'($urandom_range(255, 252));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    logic [8:0] hue;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // both ends of every sector at full saturation and value
    send_colour(9'd0, 8'd255, 8'd255);
    send_colour(9'd59, 8'd255, 8'd255);
    send_colour(9'd60, 8'd255, 8'd255);
    send_colour(9'd119, 8'd255, 8'd255);
    send_colour(9'd120, 8'd255, 8'd255);
    send_colour(9'd179, 8'd255, 8'd255);
    send_colour(9'd180, 8'd255, 8'd255);
    send_colour(9'd239, 8'd255, 8'd255);
    send_colour(9'd240, 8'd255, 8'd255);
    send_colour(9'd299, 8'd255, 8'd255);
    send_colour(9'd300, 8'd255, 8'd255);
    send_colour(9'd359, 8'd255, 8'd255);
    // grey, black, all-zero
    send_colour(9'd200, 8'd0, 8'd173);
    send_colour(9'd45, 8'd200, 8'd0);
    send_colour(9'd0, 8'd0, 8'd0);
    // hues past 359 wrap around
    send_colour(9'd360, 8'd128, 8'd200);
    send_colour(9'd450, 8'd77, 8'd255);
    send_colour(9'd511, 8'd255, 8'd255);
    // sector zero red must stay at value, small and odd levels
    send_colour(9'd30, 8'd255, 8'd200);
    send_colour(9'd256, 8'd1, 8'd254);
    send_colour(9'd1, 8'd255, 8'd1);
    send_colour(9'd330, 8'd170, 8'd85);

    // random colours, with a stretch where neither side idles
    for (int n = 0; n < RANDOM_COLOURS; n++) begin
      steady <= (n >= 400 && n < 650);
      if ($urandom_range(99) < 12) hue = 9'($urandom_range(511, 360));
      else                         hue = 9'($urandom_range(359));
      send_colour(hue, pick_level(), pick_level());
    end
    in_valid <= 1'b0;
    steady   <= 1'b0;

    // drain the pipeline, then keep watching for stray results
    while (colours_awaited != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("hsv to rgb: %0d colours sent, %0d of them with hue above 359",
             colours_sent, wrapped_sent);
    $display("hsv to rgb: %0d results compared, %0d mismatches",
             colours_checked, mismatches);
    if (mismatches == 0)
      $display("[hsv_to_rgb_converter_unit] OK");
    else
      $display("[hsv_to_rgb_converter_unit] ERROR");
    $finish;
  end

endmodule
